>>> hw/rtl/rgb2yuv_pkg.sv
`default_nettype none

package rgb2yuv_pkg;

    // Frame geometry limits.
    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = $clog2(MAX_DIM);      // position counter width
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RESET  = 13'd800;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET = 13'd450;

    // Chroma kind codes.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_U    = 2'd1;
    localparam logic [1:0] KIND_V    = 2'd2;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // A classified pixel: components plus what the back end must produce.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] kind;
        logic       frame_end;
    } pixel_item_t;

    // Last valid position for a configured dimension, with zero acting as one
    // and anything above MAX_DIM acting as MAX_DIM.
    function automatic logic [DIM_W-1:0] last_pos(input logic [CFG_DATA_W-1:0] dim);
        logic [CFG_DATA_W-1:0] dec;
        dec = dim - 13'd1;
        if (dim == '0) begin
            last_pos = '0;
        end else if (dim >= CFG_DATA_W'(MAX_DIM)) begin
            last_pos = DIM_W'(MAX_DIM - 1);
        end else begin
            last_pos = dec[DIM_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rgb_to_yuv420_stream_top.sv
`default_nettype none

// RGB to YUV 4:2:0 stream converter, BT.601 integer coefficients.
// The pixel channel (in_valid, in_stall, red, green, blue) takes one RGB pixel
// per beat in raster order. The result channel (out_valid, out_stall, luma,
// chroma_kind, chroma, frame_end) gives one beat per pixel, in the same order.
// Chroma is point-sampled: even columns of even rows carry U, even columns of
// odd rows carry V, and odd columns carry no chroma (chroma reads zero).
// frame_end marks the last pixel of each frame.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
// frame_width (index 0) and frame_height (index 1); cfg_ready is always high.
// Write it only while no pixel is in flight. Zero acts as one and sizes above
// 4096 act as 4096.
// Throughput is one pixel per clock while the receiver does not stall. A pixel
// passes through the queue, the sum stage that forms the weighted sums and the
// output register, and its result is taken at the next free edge.
// A four-entry queue sits between the classifying front end and the
// arithmetic back end; when the receiver stalls, the back end holds its
// result, the queue fills, and in_stall rises once the queue is full.
// Reset clears the column and row position, empties the queue and the
// pipeline, and restores the sizes to 800 by 450.
module rgb_to_yuv420_stream_top
    import rgb2yuv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            red,
    input  wire logic [7:0]            green,
    input  wire logic [7:0]            blue,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [7:0]                 luma,
    output logic [1:0]                 chroma_kind,
    output logic [7:0]                 chroma,
    output logic                       frame_end
);

    pixel_item_t front_item;
    pixel_item_t queue_item;
    logic        in_accept;
    logic        queue_full;
    logic        queue_empty;
    logic        queue_pop;

    assign cfg_ready = 1'b1;
    // The front end may only advance its counters when the queue has room.
    assign in_stall  = queue_full;
    assign in_accept = in_valid && !queue_full;

    rgb2yuv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (in_accept),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .item      (front_item)
    );

    rgb2yuv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_item  (queue_item),
        .empty     (queue_empty)
    );

    rgb2yuv_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_avail  (!queue_empty),
        .item        (queue_item),
        .item_take   (queue_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .luma        (luma),
        .chroma_kind (chroma_kind),
        .chroma      (chroma),
        .frame_end   (frame_end)
    );

    // Luma always lands in the BT.601 video range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (luma >= 8'd16) && (luma <= 8'd235))
        else $error("luma outside 16..235");

    // A pixel without chroma carries a zero chroma sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (chroma_kind == KIND_NONE)) |-> (chroma == 8'd0))
        else $error("chroma not zero on a pixel without chroma");

    // U and V samples stay within 16..240.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (chroma_kind != KIND_NONE)) |-> (chroma >= 8'd16) && (chroma <= 8'd240))
        else $error("chroma outside 16..240");

endmodule

`default_nettype wire

>>> hw/rtl/rgb2yuv_front.sv
`default_nettype none

module rgb2yuv_front
    import rgb2yuv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  accept,
    input  wire logic [7:0]            red,
    input  wire logic [7:0]            green,
    input  wire logic [7:0]            blue,
    output pixel_item_t                item
);

    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [DIM_W-1:0]      col_reg;
    logic [DIM_W-1:0]      col_next;
    logic [DIM_W-1:0]      row_reg;
    logic [DIM_W-1:0]      row_next;
    logic                  last_col;
    logic                  last_row;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_reg  <= FRAME_WIDTH_RESET;
            height_reg <= FRAME_HEIGHT_RESET;
        end else if (cfg_write) begin
            if (cfg_index == REG_FRAME_WIDTH) begin
                width_reg <= cfg_data;
            end else if (cfg_index == REG_FRAME_HEIGHT) begin
                height_reg <= cfg_data;
            end
        end
    end

    // A counter past the last position of a newly written size counts as last.
    assign last_col = col_reg >= last_pos(width_reg);
    assign last_row = row_reg >= last_pos(height_reg);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb begin
        item.red       = red;
        item.green     = green;
        item.blue      = blue;
        item.frame_end = last_col && last_row;
        if (col_reg[0]) begin
            item.kind = KIND_NONE;
        end else if (row_reg[0]) begin
            item.kind = KIND_V;
        end else begin
            item.kind = KIND_U;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rgb2yuv_queue.sv
`default_nettype none

module rgb2yuv_queue
    import rgb2yuv_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire pixel_item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output pixel_item_t pop_item,
    output logic       empty
);

    pixel_item_t            slots [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full     = count_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_item = slots[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rgb2yuv_back.sv
`default_nettype none

module rgb2yuv_back
    import rgb2yuv_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_avail,
    input  wire pixel_item_t item,
    output logic       item_take,
    output logic       out_valid,
    input  wire logic  out_stall,
    output logic [7:0] luma,
    output logic [1:0] chroma_kind,
    output logic [7:0] chroma,
    output logic       frame_end
);

    // Sum stage.
    logic               s1_valid_reg;
    logic [15:0]        y_sum_reg;
    logic [15:0]        c_sum_reg;
    logic [1:0]         s1_kind_reg;
    logic               s1_end_reg;
    // Output stage.
    logic               s2_valid_reg;
    logic               s2_ready;
    logic               s1_ready;
    logic [15:0]        y_sum;
    logic signed [16:0] r_s;
    logic signed [16:0] g_s;
    logic signed [16:0] b_s;
    logic signed [16:0] u_sum;
    logic signed [16:0] v_sum;

    assign s2_ready  = !s2_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign item_take = item_avail && s1_ready;
    assign out_valid = s2_valid_reg;

    assign r_s = $signed({9'd0, item.red});
    assign g_s = $signed({9'd0, item.green});
    assign b_s = $signed({9'd0, item.blue});

    assign y_sum = 16'd66 * {8'd0, item.red} + 16'd129 * {8'd0, item.green}
                 + 16'd25 * {8'd0, item.blue} + 16'd128;
    assign u_sum = 17'sd112 * b_s - 17'sd38 * r_s - 17'sd74 * g_s + 17'sd128;
    assign v_sum = 17'sd112 * r_s - 17'sd94 * g_s - 17'sd18 * b_s + 17'sd128;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= item_avail;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (item_take) begin
            y_sum_reg   <= y_sum;
            c_sum_reg   <= (item.kind == KIND_V) ? v_sum[15:0] : u_sum[15:0];
            s1_kind_reg <= item.kind;
            s1_end_reg  <= item.frame_end;
        end
        if (s2_ready && s1_valid_reg) begin
            luma        <= y_sum_reg[15:8] + 8'd16;
            chroma_kind <= s1_kind_reg;
            // floor(s / 256) + 128 for a 16-bit signed sum.
            chroma      <= (s1_kind_reg == KIND_NONE) ? 8'd0
                                                      : {~c_sum_reg[15], c_sum_reg[14:8]};
            frame_end   <= s1_end_reg;
        end
    end

endmodule

`default_nettype wire

>>> sim/rgb_to_yuv420_stream_top_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the RGB to YUV 4:2:0 stream converter.
//
// The bench keeps its own model of the converter: the two frame size
// registers and the column and row position. Every pixel beat that the block
// accepts is run through that model at the same clock edge, and the expected
// result is queued. Every result beat the block delivers is compared, field
// by field, with the oldest queued expectation.
//
// Stimulus runs as a series of named tests. Directed tests come first:
// extreme colors at the reset frame size, a resize in the middle of a frame,
// and degenerate or out-of-range frame sizes. Random frames with random sizes
// follow, under three idle patterns. A back-pressure test stalls the output
// for a long stretch while pixels keep coming, so that the block must stall
// its input.
module rgb_to_yuv420_stream_top_tb;
    import rgb2yuv_pkg::*;

    // Register indexes that the block does not decode. Writes to them must
    // leave the frame size untouched.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // One result beat as the converter should deliver it.
    typedef struct packed {
        logic [7:0] luma;
        logic [1:0] kind;
        logic [7:0] chroma;
        logic       frame_end;
    } yuv_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            red = '0;
    logic [7:0]            green = '0;
    logic [7:0]            blue = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            luma;
    logic [1:0]            chroma_kind;
    logic [7:0]            chroma;
    logic                  frame_end;

    // Model state: frame size registers and the position of the next pixel.
    logic [CFG_DATA_W-1:0] width_cfg = FRAME_WIDTH_RESET;
    logic [CFG_DATA_W-1:0] height_cfg = FRAME_HEIGHT_RESET;
    logic [11:0]           col_pos = '0;
    logic [11:0]           row_pos = '0;

    yuv_result_t pending_results[$];
    int          error_count = 0;

    // Idle percentages for the sender and the receiver, and a flag that makes
    // the receiver hold off without a break.
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_output = 1'b0;

    rgb_to_yuv420_stream_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .luma        (luma),
        .chroma_kind (chroma_kind),
        .chroma      (chroma),
        .frame_end   (frame_end)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Last valid position for a configured size. Zero behaves as one and
    // anything past the largest frame behaves as the largest frame.
    function automatic logic [11:0] last_index(input logic [CFG_DATA_W-1:0] dim);
        int span;
        span = (dim == 0) ? 1 : ((dim > MAX_DIM) ? MAX_DIM : int'(dim));
        return 12'(span - 1);
    endfunction

    // Converts one pixel at the current position and advances the position.
    // A position at or past the last one of the current size counts as the
    // last one, which covers a frame that shrinks while it is being sent.
    function automatic yuv_result_t convert_pixel(input logic [7:0] r, g, b);
        yuv_result_t res;
        int          rr;
        int          gg;
        int          bb;
        int          sum;
        logic        last_col;
        logic        last_row;
        rr = r;
        gg = g;
        bb = b;
        last_col = col_pos >= last_index(width_cfg);
        last_row = row_pos >= last_index(height_cfg);
        sum = 66 * rr + 129 * gg + 25 * bb + 128;
        res.luma = 8'((sum >>> 8) + 16);
        res.kind = KIND_NONE;
        res.chroma = '0;
        // Chroma is point-sampled on even columns: U on even rows, V on odd.
        // The offset of 32768 keeps the sum positive, so the shift floors.
        if (!col_pos[0])
        begin
            if (!row_pos[0])
            begin
                res.kind = KIND_U;
                sum = -38 * rr - 74 * gg + 112 * bb + 128;
            end
            else
            begin
                res.kind = KIND_V;
                sum = 112 * rr - 94 * gg - 18 * bb + 128;
            end
            res.chroma = 8'((sum + 32768) >>> 8);
        end
        res.frame_end = last_col && last_row;
        if (last_col)
        begin
            col_pos = '0;
            row_pos = last_row ? '0 : row_pos + 12'd1;
        end
        else
        begin
            col_pos = col_pos + 12'd1;
        end
        return res;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Bus monitor. Register writes and accepted pixel beats feed the model;
    // result beats are checked against the oldest expectation. All signals
    // are sampled at the edge, before any of them change.
    always @(posedge clk)
    begin
        yuv_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  width_cfg = cfg_data;
                    REG_FRAME_HEIGHT: height_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                pending_results.push_back(convert_pixel(red, green, blue));
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat with nothing expected: luma %0d", luma);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("luma", want.luma, luma);
                    check_field("chroma_kind", want.kind, chroma_kind);
                    check_field("chroma", want.chroma, chroma);
                    check_field("frame_end", want.frame_end, frame_end);
                end
            end
        end
    end

    // Receiver: random stalls, or a solid hold-off while hold_output is set.
    always @(posedge clk)
    begin
        out_stall <= hold_output || ($urandom_range(99) < recv_idle_pct);
    end

    task automatic set_idle(input int sender_pct, input int receiver_pct);
        send_idle_pct <= sender_pct;
        recv_idle_pct <= receiver_pct;
    endtask

    // Offers one pixel beat and returns right after the edge that took it.
    // in_valid stays high, so the next call can offer its beat without a gap.
    task automatic send_pixel(input logic [7:0] r, g, b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        red <= r;
        green <= g;
        blue <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stops offering pixels and waits until every expected result is in,
    // then lets the two-stage pipeline settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write. cfg_valid stays high so that writes can run back
    // to back; the caller lowers it after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_frame_size(input logic [CFG_DATA_W-1:0] w,
                                  input logic [CFG_DATA_W-1:0] h);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    // Mostly uniform levels, with the two extremes weighted up.
    function automatic logic [7:0] random_level();
        if ($urandom_range(5) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    // Row 0 at the reset size of 800 by 450: black, white, the primaries and
    // their complements, so U alternates with no chroma.
    task automatic test_extreme_colors();
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'hFF, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'hFF);
    endtask

    // Shrinks the frame while the position is past the new last column, so
    // the next pixel closes the row. Then runs the odd row for V extremes,
    // finishes the frame, and shrinks the height mid-row to force frame_end.
    task automatic test_resize_mid_frame();
        set_frame_size(13'd4, 13'd3);
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        repeat (4) send_pixel(random_level(), random_level(), random_level());
        repeat (3) send_pixel(random_level(), random_level(), random_level());
        set_frame_size(13'd4, 13'd1);
        send_pixel(8'h80, 8'h40, 8'hC0);
    endtask

    // Zero sizes behave as one pixel per frame, spare indexes are ignored,
    // and sizes above the largest frame are limited to it.
    task automatic test_degenerate_sizes();
        set_frame_size(13'd0, 13'd0);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_pixel(8'h00, 8'hFF, 8'h00);
        wait_idle();
        write_reg(REG_SPARE_A, 13'h1FFF);
        write_reg(REG_SPARE_B, 13'h0AAA);
        cfg_valid <= 1'b0;
        send_pixel(8'h55, 8'hAA, 8'h33);
        set_frame_size(13'h1FFF, 13'd4097);
        repeat (3) send_pixel(random_level(), random_level(), random_level());
        set_frame_size(13'd4096, 13'd4096);
        repeat (2) send_pixel(random_level(), random_level(), random_level());
    endtask

    // Whole and partial frames of random small sizes. A partial frame leaves
    // the position mid-frame, so the next resize lands inside a frame.
    task automatic test_random_frames(input int pixel_budget);
        int sent;
        int w;
        int h;
        int count;
        sent = 0;
        while (sent < pixel_budget)
        begin
            w = $urandom_range(1, 9);
            h = $urandom_range(1, 5);
            set_frame_size(13'(w), 13'(h));
            count = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
            repeat (count) send_pixel(random_level(), random_level(), random_level());
            sent += count;
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering beats, so the internal queue fills and in_stall must rise.
    task automatic test_output_backpressure();
        wait_idle();
        fork
            begin
                hold_output <= 1'b1;
                repeat (60) @(posedge clk);
                hold_output <= 1'b0;
            end
            begin
                repeat (24) send_pixel(random_level(), random_level(), random_level());
            end
        join
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle(35, 66);
        test_extreme_colors();
        test_resize_mid_frame();
        test_degenerate_sizes();
        test_random_frames(125);

        set_idle(66, 35);
        test_random_frames(125);

        set_idle(0, 0);
        test_random_frames(125);
        test_output_backpressure();

        wait_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("rgb_to_yuv420_stream_top_tb: done, clean");
        else
            $display("rgb_to_yuv420_stream_top_tb: done, errors");
        $finish;
    end

    // Watchdog: a correct run needs only a small fraction of this.
    initial
    begin
        #2000000;
        $display("rgb_to_yuv420_stream_top_tb: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/rgb2yuv_pkg.sv
hw/rtl/rgb2yuv_front.sv
hw/rtl/rgb2yuv_queue.sv
hw/rtl/rgb2yuv_back.sv
hw/rtl/rgb_to_yuv420_stream_top.sv
sim/rgb_to_yuv420_stream_top_tb.sv
